/* hdl/carc_pkg.sv */
// Shared types, codes and constants for the CAR replacement engine.
// Used by every module of the block; depends on nothing.
`default_nettype none
package carc_pkg;

  localparam int CACHE_SLOTS = 256;
  localparam int DIR_ENTRIES = 512;
  localparam int SLOT_W = 8;
  localparam int ENT_W = 9;
  localparam int CNT_W = 10;
  localparam int CAP_W = 9;
  localparam int DIV_STEPS = CNT_W;
  localparam int SWEEP_LIMIT = 2 * DIR_ENTRIES + 4;
  localparam int GUARD_W = 11;

  localparam logic [2:0] L_T1 = 3'd0;
  localparam logic [2:0] L_F1 = 3'd1;
  localparam logic [2:0] L_B1 = 3'd2;
  localparam logic [2:0] L_T2 = 3'd3;
  localparam logic [2:0] L_F2 = 3'd4;
  localparam logic [2:0] L_B2 = 3'd5;
  localparam logic [2:0] L_NONE = 3'd6;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FORGET = 3'd1;
  localparam logic [2:0] ST_REPLACE = 3'd2;
  localparam logic [2:0] ST_FAIL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_REPLACE = 2'd1;
  localparam logic [1:0] CMD_FORGET = 2'd2;
  localparam logic [1:0] CMD_TOUCH = 2'd3;

  typedef struct packed {
    logic alloc;
    logic repl;
    logic forget;
    logic touch;
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ENT_W-1:0] entry;
    logic             acc;
  } item_t;

  typedef struct packed {
    logic [2:0]        lid;
    logic              ref_bit;
    logic [SLOT_W-1:0] slot;
    logic [ENT_W-1:0]  nxt;
    logic [ENT_W-1:0]  prv;
  } rec_t;

  function automatic logic is_cached(input logic [2:0] l);
    is_cached = (l == L_T1) || (l == L_F1) || (l == L_T2) || (l == L_F2);
  endfunction

endpackage
`default_nettype wire

/* hdl/car_cache_replacement_policy.sv */
// Top level of the CAR replacement engine: front queue and back engine.
// Depends on carc_pkg, carc_front and carc_engine.
//
// Channel   Ports                                          Handshake
// input     in_command, in_entry, in_accepted              in_push / in_full
// result    out_status, out_chosen_entry, out_slot         out_pop / out_empty
// config    cfg_slots_in_use                               cfg_we
//
// An item's processing time in the engine depends on its command and path: a history hit on
// allocate includes a divide, an allocate with no free slot runs the clock sweep, and the
// time is set by the single-port directory record memory and neighbor link updates.
// After reset and after each configuration write, a clearing pass over all 512 entries
// of the directory runs; items queue in the front but are not executed.
// A waiting result holds the engine; the two-entry front queue then fills and stalls input.
`default_nettype none
module car_cache_replacement_policy (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic [1:0]                in_command,
  input  wire logic [carc_pkg::ENT_W-1:0] in_entry,
  input  wire logic                      in_accepted,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic [2:0]                     out_status,
  output logic [carc_pkg::ENT_W-1:0]      out_chosen_entry,
  output logic [carc_pkg::SLOT_W-1:0]     out_slot,
  input  wire logic                      cfg_we,
  input  wire logic [carc_pkg::CAP_W-1:0] cfg_slots_in_use
);

  logic            q_valid;
  logic            q_take;
  carc_pkg::item_t q_item;

  carc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_command  (in_command),
    .in_entry    (in_entry),
    .in_accepted (in_accepted),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_take      (q_take)
  );

  carc_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_slots_in_use (cfg_slots_in_use),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_take           (q_take),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_chosen_entry (out_chosen_entry),
    .out_slot         (out_slot)
  );

endmodule
`default_nettype wire

/* hdl/carc_front.sv */
// Front end: accepts items, decodes the command and holds them in a
// two-entry queue for the engine. Depends on carc_pkg.
`default_nettype none
module carc_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic [1:0]                in_command,
  input  wire logic [carc_pkg::ENT_W-1:0] in_entry,
  input  wire logic                      in_accepted,
  output logic                           q_valid,
  output carc_pkg::item_t                q_item,
  input  wire logic                      q_take
);

  carc_pkg::item_t buf_r [2];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;
  logic            do_push;
  logic            do_pop;
  carc_pkg::item_t dec;

  always_comb begin
    dec.op = '0;
    unique case (in_command)
      carc_pkg::CMD_ALLOC:   dec.op.alloc = 1'b1;
      carc_pkg::CMD_REPLACE: dec.op.repl = 1'b1;
      carc_pkg::CMD_FORGET:  dec.op.forget = 1'b1;
      carc_pkg::CMD_TOUCH:   dec.op.touch = 1'b1;
      default:               dec.op.touch = 1'b1;
    endcase
    dec.entry = in_entry;
    dec.acc = in_accepted;
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = buf_r[rp_r];
  assign do_push = in_push && !in_full;
  assign do_pop = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        buf_r[wp_r] <= dec;
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/carc_div.sv */
// Restoring divider for list counts, one quotient bit per cycle.
// Depends on carc_pkg.
`default_nettype none
module carc_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [carc_pkg::CNT_W-1:0] num,
  input  wire logic [carc_pkg::CNT_W-1:0] den,
  output logic                           done,
  output logic [carc_pkg::CNT_W-1:0]      quo
);

  logic [carc_pkg::CNT_W-1:0] n_r;
  logic [carc_pkg::CNT_W-1:0] d_r;
  logic [carc_pkg::CNT_W-1:0] q_r;
  logic [carc_pkg::CNT_W:0]   rem_r;
  logic [3:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [carc_pkg::CNT_W:0]   trial;
  logic                       fits;

  assign trial = {rem_r[carc_pkg::CNT_W-1:0], n_r[carc_pkg::CNT_W-1]};
  assign fits = (trial >= {1'b0, d_r});
  assign done = done_r;
  assign quo = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r <= num;
        d_r <= den;
        q_r <= '0;
        rem_r <= '0;
        cnt_r <= 4'(carc_pkg::DIV_STEPS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? trial - {1'b0, d_r} : trial;
        q_r <= {q_r[carc_pkg::CNT_W-2:0], fits};
        n_r <= {n_r[carc_pkg::CNT_W-2:0], 1'b0};
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/carc_engine.sv */
// Back end: directory records, list heads and counts, free slot stack,
// clock sweep and result register. Depends on carc_pkg and carc_div.
`default_nettype none
module carc_engine (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [carc_pkg::CAP_W-1:0] cfg_slots_in_use,
  input  wire logic                      q_valid,
  input  carc_pkg::item_t                q_item,
  output logic                           q_take,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic [2:0]                     out_status,
  output logic [carc_pkg::ENT_W-1:0]      out_chosen_entry,
  output logic [carc_pkg::SLOT_W-1:0]     out_slot
);

  localparam int EW = carc_pkg::ENT_W;
  localparam int SW = carc_pkg::SLOT_W;
  localparam int CW = carc_pkg::CNT_W;
  localparam int KW = carc_pkg::CAP_W;

  localparam logic [4:0] S_CLR = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_LOAD = 5'd2;
  localparam logic [4:0] S_VRD = 5'd3;
  localparam logic [4:0] S_VLD = 5'd4;
  localparam logic [4:0] S_UL0 = 5'd5;
  localparam logic [4:0] S_UL2 = 5'd6;
  localparam logic [4:0] S_UL4 = 5'd7;
  localparam logic [4:0] S_NBR = 5'd8;
  localparam logic [4:0] S_NBW = 5'd9;
  localparam logic [4:0] S_PT = 5'd10;
  localparam logic [4:0] S_PT2 = 5'd11;
  localparam logic [4:0] S_PH = 5'd12;
  localparam logic [4:0] S_PH2 = 5'd13;
  localparam logic [4:0] S_AL_POP = 5'd14;
  localparam logic [4:0] S_AL_SL = 5'd15;
  localparam logic [4:0] S_DIV_GO = 5'd16;
  localparam logic [4:0] S_DIV_W = 5'd17;
  localparam logic [4:0] S_SW_TOP = 5'd18;
  localparam logic [4:0] S_SW_LD = 5'd19;
  localparam logic [4:0] S_SW_WB = 5'd20;
  localparam logic [4:0] S_SW_VIC = 5'd21;
  localparam logic [4:0] S_WB_FIN = 5'd22;
  localparam logic [4:0] S_FIN = 5'd23;

  carc_pkg::rec_t    rec_mem [carc_pkg::DIR_ENTRIES];
  carc_pkg::rec_t    rec_rdata_r;
  logic [SW-1:0]     fs_mem [carc_pkg::CACHE_SLOTS];
  logic [SW-1:0]     fs_rdata_r;

  logic [4:0]        state_r;
  logic [4:0]        ul_ret_r;
  logic [4:0]        pu_ret_r;
  logic [4:0]        nb_ret_r;
  logic [EW-1:0]     clr_cnt_r;
  carc_pkg::item_t   it_r;
  logic [EW-1:0]     cur_e_r;
  carc_pkg::rec_t    cur_rec_r;
  logic [2:0]        pl_r;
  logic [EW-1:0]     nb_addr_r;
  logic              nb_nxt_r;
  logic [EW-1:0]     nb_val_r;
  logic [EW-1:0]     head_r [6];
  logic [EW-1:0]     tail_r [6];
  logic [CW-1:0]     cnt_r [6];
  logic [KW-1:0]     cap_r;
  logic [KW-1:0]     target_r;
  logic              pend_r;
  logic [KW-1:0]     fc_r;
  logic [KW-1:0]     low_r;
  logic              use_orig_r;
  logic [SW-1:0]     orig_r;
  logic [carc_pkg::GUARD_W-1:0] guard_r;
  logic              sw_t1_r;
  logic [2:0]        st_r;
  logic [EW-1:0]     ch_r;
  logic [SW-1:0]     sl_r;
  logic              res_valid_r;
  logic [2:0]        res_st_r;
  logic [EW-1:0]     res_ch_r;
  logic [SW-1:0]     res_sl_r;

  logic              rec_we;
  logic [EW-1:0]     rec_waddr;
  carc_pkg::rec_t    rec_wdata;
  logic [EW-1:0]     rec_raddr;
  logic              fs_we;
  logic [KW-1:0]     fs_idx;
  carc_pkg::rec_t    rd;
  carc_pkg::rec_t    rd_load;
  carc_pkg::rec_t    rd_clr;
  carc_pkg::rec_t    al_rec;
  logic [2:0]        rl;
  logic              free_push;
  logic [CW:0]       h1;
  logic [CW:0]       all_cnt;
  logic              from_ok;
  logic [EW-1:0]     from_tail;
  logic [KW-1:0]     lim;
  logic              t1_br;
  logic [EW-1:0]     sw_e;
  logic              div_start;
  logic [CW-1:0]     div_num;
  logic [CW-1:0]     div_den;
  logic              div_done;
  logic [CW-1:0]     div_quo;
  logic [CW-1:0]     q_eff;
  logic [CW:0]       t_sum;
  logic [SW-1:0]     slot_pick;
  logic [KW-1:0]     cap_in;
  logic              fin_load;

  assign rd = rec_rdata_r;
  assign rl = rec_rdata_r.lid;
  assign fs_idx = fc_r - KW'(1);

  always_comb begin
    rd_load = rd;
    if (it_r.op.touch || (it_r.op.repl && !it_r.acc)) begin
      rd_load.ref_bit = 1'b1;
    end
    rd_clr = rd;
    rd_clr.ref_bit = 1'b0;
    al_rec = cur_rec_r;
    al_rec.slot = slot_pick;
    al_rec.ref_bit = 1'b0;
  end

  always_comb begin
    if (cfg_slots_in_use == '0) begin
      cap_in = KW'(1);
    end else if (cfg_slots_in_use > KW'(carc_pkg::CACHE_SLOTS)) begin
      cap_in = KW'(carc_pkg::CACHE_SLOTS);
    end else begin
      cap_in = cfg_slots_in_use;
    end
  end

  always_comb begin
    h1 = (CW+1)'(cnt_r[carc_pkg::L_T1]) + (CW+1)'(cnt_r[carc_pkg::L_F1])
       + (CW+1)'(cnt_r[carc_pkg::L_B1]);
    all_cnt = h1 + (CW+1)'(cnt_r[carc_pkg::L_T2]) + (CW+1)'(cnt_r[carc_pkg::L_F2])
            + (CW+1)'(cnt_r[carc_pkg::L_B2]);
    if (h1 == (CW+1)'(cap_r)) begin
      from_ok = (cnt_r[carc_pkg::L_B1] != '0);
      from_tail = tail_r[carc_pkg::L_B1];
    end else begin
      from_ok = (all_cnt == (CW+1)'({cap_r, 1'b0})) && (cnt_r[carc_pkg::L_B2] != '0);
      from_tail = tail_r[carc_pkg::L_B2];
    end
  end

  always_comb begin
    lim = (target_r > KW'(1)) ? target_r : KW'(1);
    t1_br = ((CW+1)'(cnt_r[carc_pkg::L_T1]) + (CW+1)'(cnt_r[carc_pkg::L_F1])
             > (CW+1)'(lim)) && (cnt_r[carc_pkg::L_T1] != '0);
    sw_e = t1_br ? head_r[carc_pkg::L_T1] : head_r[carc_pkg::L_T2];
  end

  assign free_push = (state_r == S_LOAD)
                   && ((it_r.op.forget && carc_pkg::is_cached(rl))
                       || (it_r.op.repl && it_r.acc
                           && (rl == carc_pkg::L_F1 || rl == carc_pkg::L_F2)));
  assign fs_we = free_push && (fc_r < cap_r);

  assign div_start = (state_r == S_DIV_GO);
  assign div_num = (cur_rec_r.lid == carc_pkg::L_B1) ? cnt_r[carc_pkg::L_B2]
                                                      : cnt_r[carc_pkg::L_B1];
  assign div_den = (cur_rec_r.lid == carc_pkg::L_B1) ? cnt_r[carc_pkg::L_B1]
                                                      : cnt_r[carc_pkg::L_B2];
  assign q_eff = (div_den == '0 || div_quo == '0) ? CW'(1) : div_quo;
  assign t_sum = (CW+1)'(target_r) + (CW+1)'(q_eff);
  assign slot_pick = use_orig_r ? orig_r : fs_rdata_r;

  carc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    rec_we = 1'b0;
    rec_waddr = cur_e_r;
    rec_wdata = cur_rec_r;
    unique case (state_r)
      S_CLR: begin
        rec_we = 1'b1;
        rec_waddr = clr_cnt_r;
        rec_wdata = '0;
        rec_wdata.lid = carc_pkg::L_NONE;
      end
      S_NBW: begin
        rec_we = 1'b1;
        rec_waddr = nb_addr_r;
        rec_wdata = rec_rdata_r;
        if (nb_nxt_r) begin
          rec_wdata.nxt = nb_val_r;
        end else begin
          rec_wdata.prv = nb_val_r;
        end
      end
      S_WB_FIN, S_SW_WB, S_SW_VIC: begin
        rec_we = 1'b1;
      end
      default: begin
        rec_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:   rec_raddr = q_item.entry;
      S_NBR:    rec_raddr = nb_addr_r;
      S_SW_TOP: rec_raddr = sw_e;
      default:  rec_raddr = cur_e_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_rdata_r <= rec_mem[rec_raddr];
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fc_r[SW-1:0]] <= rd.slot;
    end
    fs_rdata_r <= fs_mem[fs_idx[SW-1:0]];
  end

  assign q_take = (state_r == S_IDLE) && q_valid && !cfg_we;
  assign fin_load = (state_r == S_FIN) && (!res_valid_r || out_pop);
  assign out_empty = !res_valid_r;
  assign out_status = res_st_r;
  assign out_chosen_entry = res_ch_r;
  assign out_slot = res_sl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_cnt_r <= '0;
      cap_r <= KW'(carc_pkg::CACHE_SLOTS);
      fc_r <= KW'(carc_pkg::CACHE_SLOTS);
      low_r <= KW'(carc_pkg::CACHE_SLOTS);
      target_r <= '0;
      pend_r <= 1'b0;
      res_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (fin_load) begin
        res_valid_r <= 1'b1;
        res_st_r <= st_r;
        res_ch_r <= ch_r;
        res_sl_r <= sl_r;
      end else if (out_pop && res_valid_r) begin
        res_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        state_r <= S_CLR;
        clr_cnt_r <= '0;
        cap_r <= cap_in;
        fc_r <= cap_in;
        low_r <= cap_in;
        target_r <= '0;
        pend_r <= 1'b0;
        for (int i = 0; i < 6; i++) begin
          cnt_r[i] <= '0;
        end
      end else begin
        unique case (state_r)
          S_CLR: begin
            clr_cnt_r <= clr_cnt_r + EW'(1);
            if (clr_cnt_r == EW'(carc_pkg::DIR_ENTRIES - 1)) begin
              state_r <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (q_valid) begin
              it_r <= q_item;
              cur_e_r <= q_item.entry;
              st_r <= carc_pkg::ST_DONE;
              ch_r <= '0;
              sl_r <= '0;
              state_r <= S_LOAD;
            end
          end
          S_LOAD: begin
            cur_rec_r <= rd_load;
            if (fs_we) begin
              fc_r <= fc_r + KW'(1);
            end
            priority if (it_r.op.touch) begin
              state_r <= S_WB_FIN;
            end else if (it_r.op.forget) begin
              ul_ret_r <= S_WB_FIN;
              state_r <= (rl < carc_pkg::L_NONE) ? S_UL0 : S_FIN;
            end else if (it_r.op.repl) begin
              if (rl != carc_pkg::L_F1 && rl != carc_pkg::L_F2) begin
                st_r <= carc_pkg::ST_FAIL;
                state_r <= S_FIN;
              end else if (!it_r.acc) begin
                pl_r <= rl - 3'd1;
                ul_ret_r <= S_PT;
                pu_ret_r <= S_WB_FIN;
                state_r <= S_UL0;
              end else begin
                pend_r <= 1'b1;
                pl_r <= rl + 3'd1;
                ul_ret_r <= S_PH;
                pu_ret_r <= S_WB_FIN;
                state_r <= S_UL0;
              end
            end else begin
              if (carc_pkg::is_cached(rl)) begin
                st_r <= carc_pkg::ST_FAIL;
                state_r <= S_FIN;
              end else begin
                pend_r <= 1'b0;
                if (pend_r && rl != carc_pkg::L_B1 && rl != carc_pkg::L_B2 && from_ok) begin
                  st_r <= carc_pkg::ST_FORGET;
                  ch_r <= from_tail;
                  cur_e_r <= from_tail;
                  ul_ret_r <= S_WB_FIN;
                  state_r <= S_VRD;
                end else if (fc_r == '0) begin
                  guard_r <= '0;
                  state_r <= S_SW_TOP;
                end else begin
                  state_r <= S_AL_POP;
                end
              end
            end
          end
          S_VRD: begin
            state_r <= S_VLD;
          end
          S_VLD: begin
            cur_rec_r <= rd;
            state_r <= S_UL0;
          end
          S_UL0: begin
            priority if (cur_rec_r.lid >= carc_pkg::L_NONE) begin
              state_r <= ul_ret_r;
            end else if (cnt_r[cur_rec_r.lid] == '0) begin
              state_r <= ul_ret_r;
            end else if (head_r[cur_rec_r.lid] == cur_e_r) begin
              head_r[cur_rec_r.lid] <= cur_rec_r.nxt;
              state_r <= S_UL2;
            end else begin
              nb_addr_r <= cur_rec_r.prv;
              nb_nxt_r <= 1'b1;
              nb_val_r <= cur_rec_r.nxt;
              nb_ret_r <= S_UL2;
              state_r <= S_NBR;
            end
          end
          S_UL2: begin
            if (tail_r[cur_rec_r.lid] == cur_e_r) begin
              tail_r[cur_rec_r.lid] <= cur_rec_r.prv;
              state_r <= S_UL4;
            end else begin
              nb_addr_r <= cur_rec_r.nxt;
              nb_nxt_r <= 1'b0;
              nb_val_r <= cur_rec_r.prv;
              nb_ret_r <= S_UL4;
              state_r <= S_NBR;
            end
          end
          S_UL4: begin
            cnt_r[cur_rec_r.lid] <= cnt_r[cur_rec_r.lid] - CW'(1);
            cur_rec_r.lid <= carc_pkg::L_NONE;
            state_r <= ul_ret_r;
          end
          S_NBR: begin
            state_r <= S_NBW;
          end
          S_NBW: begin
            state_r <= nb_ret_r;
          end
          S_PT: begin
            cur_rec_r.prv <= tail_r[pl_r];
            if (cnt_r[pl_r] == '0) begin
              head_r[pl_r] <= cur_e_r;
              state_r <= S_PT2;
            end else begin
              nb_addr_r <= tail_r[pl_r];
              nb_nxt_r <= 1'b1;
              nb_val_r <= cur_e_r;
              nb_ret_r <= S_PT2;
              state_r <= S_NBR;
            end
          end
          S_PT2: begin
            tail_r[pl_r] <= cur_e_r;
            cnt_r[pl_r] <= cnt_r[pl_r] + CW'(1);
            cur_rec_r.lid <= pl_r;
            state_r <= pu_ret_r;
          end
          S_PH: begin
            cur_rec_r.nxt <= head_r[pl_r];
            if (cnt_r[pl_r] == '0) begin
              tail_r[pl_r] <= cur_e_r;
              state_r <= S_PH2;
            end else begin
              nb_addr_r <= head_r[pl_r];
              nb_nxt_r <= 1'b0;
              nb_val_r <= cur_e_r;
              nb_ret_r <= S_PH2;
              state_r <= S_NBR;
            end
          end
          S_PH2: begin
            head_r[pl_r] <= cur_e_r;
            cnt_r[pl_r] <= cnt_r[pl_r] + CW'(1);
            cur_rec_r.lid <= pl_r;
            state_r <= pu_ret_r;
          end
          S_AL_POP: begin
            fc_r <= fs_idx;
            use_orig_r <= (fs_idx < low_r);
            orig_r <= SW'(cap_r - fc_r);
            if (fs_idx < low_r) begin
              low_r <= fs_idx;
            end
            state_r <= S_AL_SL;
          end
          S_AL_SL: begin
            cur_rec_r <= al_rec;
            sl_r <= slot_pick;
            st_r <= carc_pkg::ST_OK;
            if (cur_rec_r.lid == carc_pkg::L_NONE) begin
              pl_r <= carc_pkg::L_T1;
              pu_ret_r <= S_WB_FIN;
              state_r <= S_PT;
            end else begin
              state_r <= S_DIV_GO;
            end
          end
          S_DIV_GO: begin
            state_r <= S_DIV_W;
          end
          S_DIV_W: begin
            if (div_done) begin
              if (cur_rec_r.lid == carc_pkg::L_B1) begin
                target_r <= (t_sum > (CW+1)'(cap_r)) ? cap_r : t_sum[KW-1:0];
              end else begin
                target_r <= (CW'(target_r) > q_eff) ? target_r - KW'(q_eff) : '0;
              end
              pl_r <= carc_pkg::L_T2;
              ul_ret_r <= S_PT;
              pu_ret_r <= S_WB_FIN;
              state_r <= S_UL0;
            end
          end
          S_SW_TOP: begin
            if (guard_r == carc_pkg::GUARD_W'(carc_pkg::SWEEP_LIMIT)) begin
              st_r <= carc_pkg::ST_FAIL;
              state_r <= S_FIN;
            end else if (!t1_br && cnt_r[carc_pkg::L_T2] == '0) begin
              st_r <= carc_pkg::ST_FAIL;
              state_r <= S_FIN;
            end else begin
              cur_e_r <= sw_e;
              sw_t1_r <= t1_br;
              guard_r <= guard_r + carc_pkg::GUARD_W'(1);
              state_r <= S_SW_LD;
            end
          end
          S_SW_LD: begin
            cur_rec_r <= rd_clr;
            ul_ret_r <= S_PT;
            state_r <= S_UL0;
            if (!rd.ref_bit) begin
              pl_r <= sw_t1_r ? carc_pkg::L_F1 : carc_pkg::L_F2;
              pu_ret_r <= S_SW_VIC;
            end else begin
              pl_r <= carc_pkg::L_T2;
              pu_ret_r <= S_SW_WB;
            end
          end
          S_SW_WB: begin
            state_r <= S_SW_TOP;
          end
          S_SW_VIC: begin
            st_r <= carc_pkg::ST_REPLACE;
            ch_r <= cur_e_r;
            sl_r <= cur_rec_r.slot;
            state_r <= S_FIN;
          end
          S_WB_FIN: begin
            state_r <= S_FIN;
          end
          S_FIN: begin
            if (fin_load) begin
              state_r <= S_IDLE;
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* verif/carc_scoreboard.sv */
// Checker for the CAR replacement engine: keeps its own copy of the lists,
// predicts each result from the accepted items and compares. Uses carc_pkg.
`timescale 1ns / 1ps
module carc_scoreboard
  import carc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  logic [1:0]        in_command,
  input  logic [ENT_W-1:0]  in_entry,
  input  logic              in_accepted,
  input  logic              out_pop,
  input  logic              out_empty,
  input  logic [2:0]        out_status,
  input  logic [ENT_W-1:0]  out_chosen_entry,
  input  logic [SLOT_W-1:0] out_slot,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_slots_in_use,
  output int                outstanding,
  output int                mismatches
);

  typedef struct {
    logic [2:0]        status;
    logic [ENT_W-1:0]  chosen;
    logic [SLOT_W-1:0] slot;
  } outcome_t;

  outcome_t          awaited[$];
  int                capacity;
  logic [2:0]        owner[DIR_ENTRIES];
  logic [SLOT_W-1:0] held_slot[DIR_ENTRIES];
  logic              ref_bit[DIR_ENTRIES];
  int                nxt[DIR_ENTRIES];
  int                prv[DIR_ENTRIES];
  int                head[6];
  int                tail[6];
  int                cnt[6];
  int                target;
  logic              evict_pending;
  logic [SLOT_W-1:0] spare[CACHE_SLOTS];
  int                spare_cnt;

  assign outstanding = awaited.size();

  function automatic void wipe_lists();
    for (int i = 0; i < DIR_ENTRIES; i++) begin
      owner[i] = L_NONE;
      held_slot[i] = '0;
      ref_bit[i] = 1'b0;
      nxt[i] = 0;
      prv[i] = 0;
    end
    for (int i = 0; i < 6; i++) begin
      head[i] = 0;
      tail[i] = 0;
      cnt[i] = 0;
    end
    target = 0;
    evict_pending = 1'b0;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      spare[i] = (i < capacity) ? SLOT_W'(capacity - 1 - i) : '0;
    end
    spare_cnt = capacity;
  endfunction

  function automatic void detach(int e);
    int l;
    l = owner[e];
    if (l >= L_NONE || cnt[l] == 0) return;
    if (head[l] == e) head[l] = nxt[e];
    else nxt[prv[e]] = nxt[e];
    if (tail[l] == e) tail[l] = prv[e];
    else prv[nxt[e]] = prv[e];
    cnt[l]--;
    owner[e] = L_NONE;
  endfunction

  function automatic void append(int l, int e);
    prv[e] = tail[l];
    if (cnt[l] == 0) head[l] = e;
    else nxt[tail[l]] = e;
    tail[l] = e;
    cnt[l]++;
    owner[e] = 3'(l);
  endfunction

  function automatic void prepend(int l, int e);
    nxt[e] = head[l];
    if (cnt[l] == 0) tail[l] = e;
    else prv[head[l]] = e;
    head[l] = e;
    cnt[l]++;
    owner[e] = 3'(l);
  endfunction

  function automatic void relocate(int l, int e);
    detach(e);
    append(l, e);
  endfunction

  function automatic void release_slot(logic [SLOT_W-1:0] s);
    if (spare_cnt < capacity && spare_cnt < CACHE_SLOTS) begin
      spare[spare_cnt] = s;
      spare_cnt++;
    end
  endfunction

  function automatic int clock_sweep();
    int lim;
    int e;
    for (int g = 0; g < SWEEP_LIMIT; g++) begin
      lim = (target > 1) ? target : 1;
      if (cnt[L_T1] + cnt[L_F1] > lim && cnt[L_T1] > 0) begin
        e = head[L_T1];
        if (!ref_bit[e]) begin
          relocate(L_F1, e);
          return e;
        end
        ref_bit[e] = 1'b0;
        relocate(L_T2, e);
      end else begin
        if (cnt[L_T2] == 0) return -1;
        e = head[L_T2];
        if (!ref_bit[e]) begin
          relocate(L_F2, e);
          return e;
        end
        ref_bit[e] = 1'b0;
        relocate(L_T2, e);
      end
    end
    return -1;
  endfunction

  function automatic outcome_t predict_command(logic [1:0] cmd, int e, logic acc);
    outcome_t r;
    int l;
    int h1;
    int total;
    int src;
    int v;
    int q;
    r.status = ST_DONE;
    r.chosen = '0;
    r.slot = '0;
    l = owner[e];
    case (cmd)
      CMD_ALLOC: begin
        if (is_cached(3'(l))) begin
          r.status = ST_FAIL;
          return r;
        end
        if (evict_pending) begin
          evict_pending = 1'b0;
          if (l != L_B1 && l != L_B2) begin
            h1 = cnt[L_T1] + cnt[L_F1] + cnt[L_B1];
            total = h1 + cnt[L_T2] + cnt[L_F2] + cnt[L_B2];
            src = L_NONE;
            if (h1 == capacity) src = L_B1;
            else if (total == 2 * capacity) src = L_B2;
            if (src != L_NONE && cnt[src] > 0) begin
              r.chosen = ENT_W'(tail[src]);
              detach(tail[src]);
              r.status = ST_FORGET;
              return r;
            end
          end
        end
        if (spare_cnt == 0) begin
          v = clock_sweep();
          if (v < 0) begin
            r.status = ST_FAIL;
            return r;
          end
          r.chosen = ENT_W'(v);
          r.slot = held_slot[v];
          r.status = ST_REPLACE;
          return r;
        end
        ref_bit[e] = 1'b0;
        spare_cnt--;
        r.slot = spare[spare_cnt];
        held_slot[e] = r.slot;
        if (l == L_NONE) begin
          append(L_T1, e);
        end else begin
          if (l == L_B1) begin
            q = (cnt[L_B1] != 0) ? cnt[L_B2] / cnt[L_B1] : 0;
            if (q < 1) q = 1;
            target = (target + q > capacity) ? capacity : target + q;
          end else begin
            q = (cnt[L_B2] != 0) ? cnt[L_B1] / cnt[L_B2] : 0;
            if (q < 1) q = 1;
            target = (target > q) ? target - q : 0;
          end
          relocate(L_T2, e);
        end
        r.status = ST_OK;
      end
      CMD_REPLACE: begin
        if (l != L_F1 && l != L_F2) begin
          r.status = ST_FAIL;
        end else if (!acc) begin
          ref_bit[e] = 1'b1;
          relocate(l - 1, e);
        end else begin
          release_slot(held_slot[e]);
          detach(e);
          prepend(l + 1, e);
          evict_pending = 1'b1;
        end
      end
      CMD_FORGET: begin
        if (is_cached(3'(l))) release_slot(held_slot[e]);
        if (l < L_NONE) detach(e);
      end
      default: begin
        ref_bit[e] = 1'b1;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      capacity = CACHE_SLOTS;
      wipe_lists();
      awaited.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) begin
        capacity = (cfg_slots_in_use < 1) ? 1 :
                   (cfg_slots_in_use > CACHE_SLOTS) ? CACHE_SLOTS : int'(cfg_slots_in_use);
        wipe_lists();
      end
      if (in_push && !in_full) begin
        awaited.push_back(predict_command(in_command, int'(in_entry), in_accepted));
      end
      if (out_pop && !out_empty) begin
        if (awaited.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: status %0d entry %0d slot %0d",
                     out_status, out_chosen_entry, out_slot);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = awaited.pop_front();
          if (want.status !== out_status || want.chosen !== out_chosen_entry ||
              want.slot !== out_slot) begin
            if (mismatches < 10) begin
              $display("mismatch: expected status %0d entry %0d slot %0d, got %0d %0d %0d",
                       want.status, want.chosen, want.slot,
                       out_status, out_chosen_entry, out_slot);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

/* verif/testbench.sv */
// Top of the CAR replacement engine testbench: clock, reset, stimulus and
// verdict. Depends on carc_pkg, car_cache_replacement_policy, carc_scoreboard.
`timescale 1ns / 1ps
module testbench;
  import carc_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic [1:0]        in_command;
  logic [ENT_W-1:0]  in_entry;
  logic              in_accepted;
  logic              out_empty;
  logic              out_pop;
  logic [2:0]        out_status;
  logic [ENT_W-1:0]  out_chosen_entry;
  logic [SLOT_W-1:0] out_slot;
  logic              cfg_we;
  logic [CAP_W-1:0]  cfg_slots_in_use;
  int                outstanding;
  int                mismatches;
  int                stall_requests;
  int                idle_cycles;
  int                capacity;
  int                pool_base;
  logic [ENT_W-1:0]  victims[$];

  car_cache_replacement_policy i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_command(in_command),
    .in_entry(in_entry), .in_accepted(in_accepted),
    .out_empty(out_empty), .out_pop(out_pop), .out_status(out_status),
    .out_chosen_entry(out_chosen_entry), .out_slot(out_slot),
    .cfg_we(cfg_we), .cfg_slots_in_use(cfg_slots_in_use)
  );

  carc_scoreboard i_scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_command(in_command),
    .in_entry(in_entry), .in_accepted(in_accepted),
    .out_pop(out_pop), .out_empty(out_empty), .out_status(out_status),
    .out_chosen_entry(out_chosen_entry), .out_slot(out_slot),
    .cfg_we(cfg_we), .cfg_slots_in_use(cfg_slots_in_use),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random pops, occasional long pauses, and a long hold on request.
  initial begin
    int hold;
    int seen;
    hold = 0;
    seen = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_requests != seen) begin
        seen = stall_requests;
        hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        out_pop <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        hold = $urandom_range(20, 80);
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty && out_status == ST_REPLACE) begin
      victims.push_back(out_chosen_entry);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_cmd(input logic [1:0] cmd, input int e, input logic acc);
    int gap;
    in_push <= 1'b1;
    in_command <= cmd;
    in_entry <= ENT_W'(e);
    in_accepted <= acc;
    do @(posedge clk); while (in_full);
    gap = $urandom_range(0, 99);
    if (gap >= 60) begin
      in_push <= 1'b0;
      repeat (gap < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_capacity(input int value);
    drain();
    cfg_we <= 1'b1;
    cfg_slots_in_use <= CAP_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity = (value < 1) ? 1 : (value > CACHE_SLOTS) ? CACHE_SLOTS : value;
    victims.delete();
  endtask

  function automatic int pool_entry();
    return (pool_base + $urandom_range(0, 3 * capacity + 1)) % DIR_ENTRIES;
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_cmd(CMD_ALLOC, pool_entry(), 1'b0);
    end else if (r < 70 && victims.size() != 0) begin
      send_cmd(CMD_REPLACE, victims.pop_front(), $urandom_range(0, 99) < 80);
    end else if (r < 80) begin
      send_cmd(CMD_TOUCH, pool_entry(), 1'($urandom_range(0, 1)));
    end else if (r < 88) begin
      send_cmd(CMD_FORGET, pool_entry(), 1'($urandom_range(0, 1)));
    end else if (r < 93) begin
      send_cmd(CMD_REPLACE, pool_entry(), 1'($urandom_range(0, 1)));
    end else begin
      send_cmd(2'($urandom_range(0, 3)), $urandom_range(0, DIR_ENTRIES - 1),
               1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int settings[11];
    rst_n = 1'b0;
    in_push = 1'b0;
    in_command = CMD_ALLOC;
    in_entry = '0;
    in_accepted = 1'b0;
    cfg_we = 1'b0;
    cfg_slots_in_use = '0;
    stall_requests = 0;
    capacity = CACHE_SLOTS;
    pool_base = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset capacity, field extremes, then a tiny cache for sweeps.
    send_cmd(CMD_ALLOC, 0, 1'b0);
    send_cmd(CMD_ALLOC, DIR_ENTRIES - 1, 1'b1);
    send_cmd(CMD_ALLOC, 0, 1'b0);
    send_cmd(CMD_TOUCH, DIR_ENTRIES - 1, 1'b0);
    send_cmd(CMD_REPLACE, 0, 1'b1);
    send_cmd(CMD_FORGET, DIR_ENTRIES - 1, 1'b0);
    send_cmd(CMD_FORGET, DIR_ENTRIES - 1, 1'b0);
    send_cmd(CMD_TOUCH, 300, 1'b1);
    write_capacity(2);
    send_cmd(CMD_ALLOC, 1, 1'b0);
    send_cmd(CMD_ALLOC, 2, 1'b0);
    send_cmd(CMD_ALLOC, 3, 1'b0);
    send_cmd(CMD_REPLACE, 1, 1'b0);
    send_cmd(CMD_ALLOC, 3, 1'b0);
    send_cmd(CMD_REPLACE, 2, 1'b1);
    send_cmd(CMD_ALLOC, 3, 1'b0);
    send_cmd(CMD_ALLOC, 3, 1'b0);
    send_cmd(CMD_ALLOC, 2, 1'b0);
    send_cmd(CMD_TOUCH, 3, 1'b0);
    send_cmd(CMD_ALLOC, 4, 1'b0);
    drain();
    while (victims.size() != 0) send_cmd(CMD_REPLACE, victims.pop_front(), 1'b1);
    send_cmd(CMD_ALLOC, 1, 1'b0);
    send_cmd(CMD_ALLOC, 2, 1'b0);

    settings = '{1, 0, 8, 511, 4, 16, 3, 37, 256, 12, 6};
    foreach (settings[k]) begin
      write_capacity(settings[k]);
      pool_base = $urandom_range(0, DIR_ENTRIES - 1);
      if (k == 2) stall_requests++;
      repeat (155) random_item();
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
